### rtl/core/bra_pkg.sv
package bra_pkg;

    localparam int MAP_BITS  = 1024;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W     = $clog2(MAP_BITS) + 1;
    localparam int POS_W     = $clog2(MAP_BITS);
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int ADDR_W    = $clog2(MAP_WORDS);

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_SET   = 2'd1;
    localparam logic [1:0] FUNC_TEST  = 2'd2;
    localparam logic [1:0] FUNC_RSVD  = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_NEXT  = 2'd1;
    localparam logic [1:0] POL_BEST  = 2'd2;
    localparam logic [1:0] POL_RSVD  = 2'd3;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SIZE   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_WIN,
        ST_SCAN,
        ST_BEST,
        ST_HIT,
        ST_WRITE,
        ST_TEST,
        ST_DONE
    } bra_state_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [ADDR_W-1:0]    raddr;
    } bra_ram_req_t;

endpackage

### rtl/core/bra_map_ram.sv
module bra_map_ram (
    input  logic                          clk,
    input  bra_pkg::bra_ram_req_t         req,
    output logic [bra_pkg::WORD_BITS-1:0] rdata
);
    import bra_pkg::*;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

### rtl/core/bitmap_run_allocator.sv
// Channel   Handshake               Payload
// request   in_valid / in_ready     func, start_index, run_length, match_value
// result    out_valid / out_ready   found, run_index, bit_read
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The map lives in one word-wide RAM and is walked one bit per cycle, pausing
// while each new word is fetched; an ignored function goes straight to the result.
// A flip or set range is written bit by bit, with a write-back per word.
// After reset the RAM is cleared word by word, all 16 words; no request is taken meanwhile.
// A new request is taken while an earlier result still waits in the output register.
module bitmap_run_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [bra_pkg::IDX_W-1:0]   start_index,
    input  logic [bra_pkg::IDX_W-1:0]   run_length,
    input  logic                        match_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [bra_pkg::POS_W-1:0]   run_index,
    output logic                        bit_read,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [bra_pkg::IDX_W-1:0]   cfg_data
);
    import bra_pkg::*;

    bra_state_t state_reg, state_next, mode_reg, mode_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next, end_reg, end_next, run_reg, run_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [IDX_W-1:0]     last_reg, last_next, start_reg, start_next;
    logic [IDX_W-1:0]     at_reg, at_next, best_reg, best_next, cs_reg, cs_next;
    logic                 val_reg, val_next, wval_reg, wval_next;
    logic                 pass_reg, pass_next, have_reg, have_next;
    logic [WORD_BITS-1:0] wbuf_reg, wbuf_next, wbuf_mod;
    logic [ADDR_W-1:0]    waddr_reg, waddr_next, clr_reg, clr_next;
    logic                 res_found_reg, res_found_next, res_bit_reg, res_bit_next;
    logic [POS_W-1:0]     res_idx_reg, res_idx_next, pos_reg, pos_next;
    logic                 out_valid_reg, out_valid_next, found_reg, found_next;
    logic                 bit_reg, bit_next;
    logic [POS_W-1:0]     idx_reg, idx_next;
    logic [1:0]           policy_reg;
    logic [IDX_W-1:0]     size_reg;

    logic [IDX_W-1:0]     n_used, pos_ext, lim, run_inc, blen;
    logic [IDX_W:0]       range_end;
    logic                 cur_bit, closing;
    logic [WORD_BITS-1:0] rdata;
    bra_ram_req_t         ram_req;

    bra_map_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    assign n_used    = (size_reg > IDX_W'(MAP_BITS)) ? IDX_W'(MAP_BITS) : size_reg;
    assign pos_ext   = {1'b0, pos_reg};
    assign range_end = {1'b0, start_index} + {1'b0, run_length};
    assign lim       = (range_end > {1'b0, n_used}) ? n_used : range_end[IDX_W-1:0];
    assign cur_bit   = wbuf_reg[ptr_reg[OFF_W-1:0]];
    assign run_inc   = run_reg + IDX_W'(1);

    always_comb
    begin
        wbuf_mod = wbuf_reg;
        wbuf_mod[ptr_reg[OFF_W-1:0]] = wval_reg;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign run_index = idx_reg;
    assign bit_read  = bit_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        last_next      = last_reg;
        start_next     = start_reg;
        at_next        = at_reg;
        best_next      = best_reg;
        cs_next        = cs_reg;
        val_next       = val_reg;
        wval_next      = wval_reg;
        pass_next      = pass_reg;
        have_next      = have_reg;
        wbuf_next      = wbuf_reg;
        waddr_next     = waddr_reg;
        clr_next       = clr_reg;
        res_found_next = res_found_reg;
        res_bit_next   = res_bit_reg;
        res_idx_next   = res_idx_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        bit_next       = bit_reg;
        idx_next       = idx_reg;
        closing        = 1'b0;
        blen           = run_reg;
        ram_req.we     = 1'b0;
        ram_req.waddr  = waddr_reg;
        ram_req.wdata  = wbuf_mod;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = '0;
                clr_next      = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_found_next = 1'b0;
                    res_bit_next   = 1'b0;
                    res_idx_next   = '0;
                    start_next     = start_index;
                    cnt_next       = run_length;
                    val_next       = match_value;
                    state_next     = ST_DONE;
                    unique case (func)
                        FUNC_TEST:
                        begin
                            if (start_index < n_used)
                            begin
                                ptr_next   = start_index;
                                mode_next  = ST_TEST;
                                state_next = ST_LOAD;
                            end
                        end
                        FUNC_SET:
                        begin
                            if (start_index < n_used && run_length != '0)
                            begin
                                cnt_next   = lim - start_index;
                                wval_next  = match_value;
                                ptr_next   = start_index;
                                mode_next  = ST_WRITE;
                                state_next = ST_LOAD;
                            end
                        end
                        FUNC_ALLOC:
                        begin
                            last_next = n_used - run_length;
                            if (run_length <= n_used)
                            begin
                                if (policy_reg == POL_FIRST)
                                begin
                                    lo_next    = start_index;
                                    hi_next    = n_used - run_length;
                                    pass_next  = 1'b1;
                                    state_next = ST_WIN;
                                end
                                else if (policy_reg == POL_NEXT)
                                begin
                                    lo_next    = pos_ext;
                                    hi_next    = n_used - run_length;
                                    pass_next  = 1'b0;
                                    state_next = ST_WIN;
                                end
                                else if (policy_reg == POL_BEST && start_index < n_used)
                                begin
                                    ptr_next   = start_index;
                                    end_next   = n_used - IDX_W'(1);
                                    run_next   = '0;
                                    have_next  = 1'b0;
                                    mode_next  = ST_BEST;
                                    state_next = ST_LOAD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                wbuf_next  = rdata;
                waddr_next = ptr_reg[POS_W-1:OFF_W];
                state_next = mode_reg;
            end
            ST_WIN:
            begin
                if (lo_reg > hi_reg)
                begin
                    if (!pass_reg)
                    begin
                        // Second next-fit pass wraps back to the request's start.
                        pass_next = 1'b1;
                        lo_next   = start_reg;
                        hi_next   = (pos_ext < last_reg) ? pos_ext : last_reg;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    at_next    = lo_reg;
                    state_next = ST_HIT;
                end
                else
                begin
                    ptr_next   = lo_reg;
                    end_next   = hi_reg + cnt_reg - IDX_W'(1);
                    run_next   = '0;
                    mode_next  = ST_SCAN;
                    state_next = ST_LOAD;
                end
            end
            ST_SCAN:
            begin
                run_next = (cur_bit == val_reg) ? run_inc : '0;
                if (cur_bit == val_reg && run_inc >= cnt_reg)
                begin
                    at_next    = ptr_reg + IDX_W'(1) - cnt_reg;
                    state_next = ST_HIT;
                end
                else if (ptr_reg == end_reg)
                begin
                    // Force an empty window so ST_WIN starts the second next-fit pass or fails.
                    lo_next    = IDX_W'(1);
                    hi_next    = '0;
                    state_next = ST_WIN;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                    if (ptr_reg[OFF_W-1:0] == '1)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_BEST:
            begin
                if (cur_bit == val_reg)
                begin
                    run_next = run_inc;
                    blen     = run_inc;
                    if (run_reg == '0)
                    begin
                        cs_next = ptr_reg;
                    end
                    closing = (ptr_reg == end_reg);
                end
                else
                begin
                    run_next = '0;
                    closing  = (run_reg != '0);
                end
                if (closing && blen >= cnt_reg && (!have_reg || blen < best_reg))
                begin
                    have_next = 1'b1;
                    best_next = blen;
                    at_next   = (cur_bit == val_reg && run_reg == '0) ? ptr_reg : cs_reg;
                end
                if (ptr_reg == end_reg)
                begin
                    state_next = have_next ? ST_HIT : ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                    if (ptr_reg[OFF_W-1:0] == '1)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_HIT:
            begin
                res_found_next = 1'b1;
                res_idx_next   = at_reg[POS_W-1:0];
                if (policy_reg == POL_NEXT)
                begin
                    pos_next = at_reg[POS_W-1:0];
                end
                if (cnt_reg != '0)
                begin
                    ptr_next   = at_reg;
                    wval_next  = ~val_reg;
                    mode_next  = ST_WRITE;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WRITE:
            begin
                wbuf_next = wbuf_mod;
                cnt_next  = cnt_reg - IDX_W'(1);
                ptr_next  = ptr_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(1) || ptr_reg[OFF_W-1:0] == '1)
                begin
                    ram_req.we = 1'b1;
                    state_next = (cnt_reg == IDX_W'(1)) ? ST_DONE : ST_LOAD;
                end
            end
            ST_TEST:
            begin
                res_bit_next = cur_bit;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    idx_next       = res_idx_reg;
                    bit_next       = res_bit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The RAM always fetches the word holding the next pointer.
        ram_req.raddr = ptr_next[POS_W-1:OFF_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mode_reg      <= ST_IDLE;
            clr_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            policy_reg    <= POL_FIRST;
            size_reg      <= IDX_W'(MAP_BITS);
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_POLICY: policy_reg <= cfg_data[1:0];
                    REG_SIZE:   size_reg   <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        run_reg       <= run_next;
        cnt_reg       <= cnt_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        last_reg      <= last_next;
        start_reg     <= start_next;
        at_reg        <= at_next;
        best_reg      <= best_next;
        cs_reg        <= cs_next;
        val_reg       <= val_next;
        wval_reg      <= wval_next;
        pass_reg      <= pass_next;
        have_reg      <= have_next;
        wbuf_reg      <= wbuf_next;
        waddr_reg     <= waddr_next;
        res_found_reg <= res_found_next;
        res_bit_reg   <= res_bit_next;
        res_idx_reg   <= res_idx_next;
        found_reg     <= found_next;
        bit_reg       <= bit_next;
        idx_reg       <= idx_next;
    end

`ifndef SYNTHESIS
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request accepted during RAM clear");

    a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (state_reg == ST_CLEAR || state_reg == ST_WRITE))
        else $error("RAM written outside clear or write states");

    a_hit_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HIT) |=> res_found_reg)
        else $error("hit did not record found");

    a_pos_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != $past(pos_reg)) |-> ($past(state_reg) == ST_HIT))
        else $error("next-fit position changed without a hit");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bra_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] func;
    logic [IDX_W-1:0] start_index;
    logic [IDX_W-1:0] run_length;
    logic match_value;
    logic out_valid;
    logic out_ready;
    logic found;
    logic [POS_W-1:0] run_index;
    logic bit_read;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [IDX_W-1:0] cfg_data;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] run_index;
        logic             bit_read;
    } alloc_result_t;

    bitmap_run_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .start_index(start_index), .run_length(run_length),
        .match_value(match_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .run_index(run_index), .bit_read(bit_read),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    // Shadow copy of the page map and allocator registers.
    logic [MAP_BITS-1:0] shadow_map;
    logic [POS_W-1:0]    shadow_next_pos;
    logic [1:0]          shadow_policy;
    logic [IDX_W-1:0]    shadow_size;

    alloc_result_t pending_results[$];
    int  error_count;
    int  results_seen;
    int  found_seen;
    longint cycle_count;
    int  burst_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int used_bits();
        return (shadow_size > MAP_BITS) ? MAP_BITS : int'(shadow_size);
    endfunction

    function automatic bit scan_window(input int lo, input int hi, input int cnt,
                                       input bit v, output int at);
        int run;
        run = 0;
        at = 0;
        if (lo > hi)
            return 0;
        if (cnt == 0)
        begin
            at = lo;
            return 1;
        end
        for (int i = lo; i <= hi + cnt - 1; i++)
        begin
            run = (shadow_map[i] == v) ? run + 1 : 0;
            if (run >= cnt)
            begin
                at = i + 1 - cnt;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic bit scan_best(input int lo, input int n, input int cnt,
                                     input bit v, output int at);
        int i;
        int s;
        int best_len;
        bit have;
        i = lo;
        best_len = 0;
        have = 0;
        at = 0;
        while (i < n)
        begin
            if (shadow_map[i] == v)
            begin
                s = i;
                while (i < n && shadow_map[i] == v)
                    i++;
                if (i - s >= cnt && (!have || i - s < best_len))
                begin
                    have = 1;
                    best_len = i - s;
                    at = s;
                end
            end
            else
                i++;
        end
        return have;
    endfunction

    function automatic alloc_result_t predict_request(input logic [1:0] f,
        input logic [IDX_W-1:0] st, input logic [IDX_W-1:0] len, input logic v);
        alloc_result_t r;
        int n;
        int last;
        int at;
        int pos;
        bit ok;
        r = '0;
        n = used_bits();
        at = 0;
        ok = 0;
        if (f == FUNC_ALLOC)
        begin
            if (int'(len) <= n)
            begin
                last = n - int'(len);
                if (shadow_policy == POL_FIRST)
                    ok = scan_window(int'(st), last, int'(len), v, at);
                else if (shadow_policy == POL_NEXT)
                begin
                    pos = int'(shadow_next_pos);
                    ok = scan_window(pos, last, int'(len), v, at);
                    if (!ok)
                        ok = scan_window(int'(st), (pos < last) ? pos : last,
                                         int'(len), v, at);
                    if (ok)
                        shadow_next_pos = at[POS_W-1:0];
                end
                else if (shadow_policy == POL_BEST)
                    ok = scan_best(int'(st), n, int'(len), v, at);
                if (ok)
                begin
                    for (int i = 0; i < int'(len); i++)
                        shadow_map[at + i] = ~v;
                    r.found = 1'b1;
                    r.run_index = at[POS_W-1:0];
                end
            end
        end
        else if (f == FUNC_SET)
        begin
            for (int i = 0; i < int'(len); i++)
                if (int'(st) + i < n)
                    shadow_map[int'(st) + i] = v;
        end
        else if (f == FUNC_TEST)
        begin
            if (int'(st) < n)
                r.bit_read = shadow_map[st];
        end
        return r;
    endfunction

    // Receiver stalls at random, with calm stretches in which it is always ready.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if ((cycle_count / 3000) % 3 == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (found) found_seen <= found_seen + 1;
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    error_count++;
                end
                if (run_index !== want.run_index)
                begin
                    $error("run_index: expected %0d, got %0d", want.run_index, run_index);
                    error_count++;
                end
                if (bit_read !== want.bit_read)
                begin
                    $error("bit_read: expected %0d, got %0d", want.bit_read, bit_read);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic [1:0] f, input logic [IDX_W-1:0] st,
                                input logic [IDX_W-1:0] len, input logic v);
        if (burst_left == 0)
        begin
            // Bursts are separated by idle stretches with in_valid low.
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        func <= f;
        start_index <= st;
        run_length <= len;
        match_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_request(f, st, len, v));
        @(negedge clk);
        if (burst_left == 0)
            in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        wait (pending_results.size() == 0);
        // Leave a quiet stretch before the next step.
        repeat (2600) @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [IDX_W-1:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_POLICY)
            shadow_policy = data[1:0];
        else
            shadow_size = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [IDX_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 11'($urandom_range(0, 2047));
            1:       return 11'($urandom_range(0, 1024));
            default: return 11'($urandom_range(0, 24));
        endcase
    endfunction

    task automatic test_directed();
        send_request(FUNC_TEST, 11'd0, 11'd0, 1'b0);
        send_request(FUNC_ALLOC, 11'd0, 11'd8, 1'b0);
        send_request(FUNC_ALLOC, 11'd0, 11'd0, 1'b0);
        send_request(FUNC_ALLOC, 11'd0, 11'd1024, 1'b0);
        send_request(FUNC_ALLOC, 11'd0, 11'd1025, 1'b0);
        send_request(FUNC_ALLOC, 11'd2047, 11'd1, 1'b0);
        send_request(FUNC_SET, 11'd1000, 11'd2047, 1'b1);
        send_request(FUNC_TEST, 11'd1023, 11'd0, 1'b1);
        send_request(FUNC_TEST, 11'd2047, 11'd2047, 1'b1);
        send_request(FUNC_ALLOC, 11'd500, 11'd10, 1'b1);
        send_request(FUNC_RSVD, 11'd5, 11'd5, 1'b1);
        send_request(FUNC_SET, 11'd0, 11'd1024, 1'b0);
        write_register(REG_POLICY, 11'(POL_NEXT));
        send_request(FUNC_ALLOC, 11'd0, 11'd16, 1'b0);
        send_request(FUNC_ALLOC, 11'd0, 11'd16, 1'b0);
        send_request(FUNC_ALLOC, 11'd0, 11'd0, 1'b1);
        write_register(REG_POLICY, 11'(POL_BEST));
        send_request(FUNC_SET, 11'd100, 11'd5, 1'b1);
        send_request(FUNC_ALLOC, 11'd0, 11'd3, 1'b1);
        send_request(FUNC_ALLOC, 11'd0, 11'd0, 1'b1);
        write_register(REG_POLICY, 11'(POL_RSVD));
        send_request(FUNC_ALLOC, 11'd0, 11'd1, 1'b0);
        write_register(REG_SIZE, 11'd0);
        send_request(FUNC_ALLOC, 11'd0, 11'd0, 1'b0);
        send_request(FUNC_TEST, 11'd0, 11'd0, 1'b0);
        write_register(REG_SIZE, 11'd2047);
        send_request(FUNC_TEST, 11'd1023, 11'd0, 1'b0);
    endtask

    task automatic test_random_phase(input int count);
        logic [1:0] f;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 19))
                0:               f = FUNC_RSVD;
                1, 2, 3, 4:      f = FUNC_SET;
                5, 6, 7:         f = FUNC_TEST;
                default:         f = FUNC_ALLOC;
            endcase
            send_request(f,
                ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                            : 11'($urandom_range(0, 1023)),
                pick_length(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random();
        logic [IDX_W-1:0] sizes[5];
        sizes = '{11'd1024, 11'd64, 11'd2047, 11'd1, 11'($urandom_range(2, 1023))};
        for (int p = 0; p < 12; p++)
        begin
            write_register(REG_POLICY, 11'(p % 3));
            write_register(REG_SIZE, sizes[p % 5]);
            test_random_phase(165);
            if (p == 5)
            begin
                // Hold the sender back until the block has fully caught up.
                drain_results();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        start_index = '0;
        run_length = '0;
        match_value = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        shadow_map = '0;
        shadow_next_pos = '0;
        shadow_policy = POL_FIRST;
        shadow_size = 11'd1024;
        error_count = 0;
        results_seen = 0;
        found_seen = 0;
        cycle_count = 0;
        burst_left = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();

        drain_results();
        $display("Covered %0d requests (%0d runs found) over all fit policies",
                 results_seen, found_seen);
        $display("and map sizes from 0 to past the map end.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
